// ===== src/icws_pkg.sv =====
// package for the i/o counter window statistics unit
// shared constants, item and result types; no dependencies
`timescale 1ns / 1ps
package icws_pkg;
  localparam int Devices = 255;
  localparam int History = 64;
  localparam int Rows = Devices + 1;
  localparam int DevW = $clog2(Devices + 1);
  localparam int RowW = $clog2(Rows);
  localparam int SlotW = $clog2(History);
  localparam int HistDepth = Rows * History;
  localparam int HistAw = $clog2(HistDepth);
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_INTERVAL = 2'd1;
  localparam logic [1:0] FUNC_QDEV = 2'd2;
  localparam logic [1:0] FUNC_QTOT = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [3:0] SEL_BAD = 4'd15;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] dev_key;
    logic [63:0] bytes_read;
    logic [63:0] bytes_written;
    logic [31:0] read_ops;
    logic [31:0] write_ops;
    logic [31:0] wait_count;
    logic [31:0] run_count;
    logic [3:0]  stat_sel;
  } item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  value_frac;
    logic [1:0]  status;
  } result_t;
endpackage

// ===== src/icws_ram.sv =====
// generic single-port-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module icws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/icws_queue.sv =====
// short fifo of items between front and back
// depends on icws_pkg
`timescale 1ns / 1ps
module icws_queue
  import icws_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output item_t dout,
  output logic  empty
);
  item_t mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0] cnt_r;

  assign full = (cnt_r == (QPtrW + 1)'(QDepth));
  assign empty = (cnt_r == '0);
  assign dout = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        mem_r[wp_r] <= din;
        wp_r <= wp_r + 1'b1;
      end
      if (pop && !empty) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPtrW + 1)'(push && !full) - (QPtrW + 1)'(pop && !empty);
    end
  end
endmodule

// ===== src/icws_back.sv =====
// back end: device lookup, history update, totals and window statistics
// depends on icws_pkg and icws_ram
`timescale 1ns / 1ps
module icws_back
  import icws_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready,
  output logic    clr_busy
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_LOOKCHK, S_SAMPLE, S_SUM, S_SUMACC, S_TOT,
    S_QRY, S_QACC, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  item_t it_r;
  logic [DevW-1:0] nused_r;
  logic [DevW-1:0] idx_r;
  logic [SlotW-1:0] cur_r;
  logic [HistAw-1:0] clr_r;
  logic [SlotW:0] k_r;
  logic [RowW-1:0] row_r;
  logic [63:0] sw0_r, sw1_r;
  logic [31:0] sn0_r, sn1_r, sn2_r;
  logic [63:0] sum_r, mn_r, mx_r;
  logic [63:0] fx;
  logic first_r, pend_r;
  result_t res_r;
  logic res_valid_r;

  // per-device tables
  logic [DevW-1:0] d_addr;
  logic d_we;
  logic [63:0] key_q, lbr_q, lbw_q;
  logic [31:0] lro_q, lwo_q;

  // history: two wide series, three narrow series
  logic h_we;
  logic [HistAw-1:0] h_waddr, h_raddr;
  logic [63:0] hw_wd [2];
  logic [31:0] hn_wd [3];
  logic [63:0] hw_q [2];
  logic [31:0] hn_q [3];

  logic [3:0] sel;
  logic [2:0] series;
  logic [1:0] kind;
  logic [63:0] elem;

  assign sel = it_r.stat_sel;
  always_comb begin
    if (sel < 4'd3) series = 3'd0;
    else if (sel < 4'd6) series = 3'd1;
    else if (sel < 4'd9) series = 3'd2;
    else if (sel < 4'd12) series = 3'd3;
    else series = 3'd4;
    kind = 2'(sel - 4'(series) * 4'd3);
    case (series)
      3'd0: elem = {32'd0, hn_q[0]};
      3'd1: elem = {32'd0, hn_q[1]};
      3'd2: elem = {32'd0, hn_q[2]};
      3'd3: elem = hw_q[0];
      default: elem = hw_q[1];
    endcase
  end

  // narrow averages: floor(sum * 256 / History)
  assign fx = (sum_r << 8) >> SlotW;

  icws_ram #(.Width(64), .Depth(Devices)) u_key (.clk, .we(d_we && first_r),
    .waddr(d_addr[$clog2(Devices)-1:0]), .wdata(it_r.dev_key),
    .raddr(d_addr[$clog2(Devices)-1:0]), .rdata(key_q));
  icws_ram #(.Width(64), .Depth(Devices)) u_lbr (.clk, .we(d_we),
    .waddr(d_addr[$clog2(Devices)-1:0]), .wdata(it_r.bytes_read),
    .raddr(d_addr[$clog2(Devices)-1:0]), .rdata(lbr_q));
  icws_ram #(.Width(64), .Depth(Devices)) u_lbw (.clk, .we(d_we),
    .waddr(d_addr[$clog2(Devices)-1:0]), .wdata(it_r.bytes_written),
    .raddr(d_addr[$clog2(Devices)-1:0]), .rdata(lbw_q));
  icws_ram #(.Width(32), .Depth(Devices)) u_lro (.clk, .we(d_we),
    .waddr(d_addr[$clog2(Devices)-1:0]), .wdata(it_r.read_ops),
    .raddr(d_addr[$clog2(Devices)-1:0]), .rdata(lro_q));
  icws_ram #(.Width(32), .Depth(Devices)) u_lwo (.clk, .we(d_we),
    .waddr(d_addr[$clog2(Devices)-1:0]), .wdata(it_r.write_ops),
    .raddr(d_addr[$clog2(Devices)-1:0]), .rdata(lwo_q));

  genvar g;
  generate
    for (g = 0; g < 2; g++) begin : g_wide
      icws_ram #(.Width(64), .Depth(HistDepth)) u_hw (.clk, .we(h_we),
        .waddr(h_waddr), .wdata(hw_wd[g]), .raddr(h_raddr), .rdata(hw_q[g]));
    end
    for (g = 0; g < 3; g++) begin : g_narrow
      icws_ram #(.Width(32), .Depth(HistDepth)) u_hn (.clk, .we(h_we),
        .waddr(h_waddr), .wdata(hn_wd[g]), .raddr(h_raddr), .rdata(hn_q[g]));
    end
  endgenerate

  assign d_addr = idx_r;

  always_comb begin
    h_we = 1'b0;
    h_waddr = {row_r, cur_r};
    h_raddr = {row_r, cur_r};
    d_we = 1'b0;
    hw_wd[0] = it_r.bytes_read - lbr_q;
    hw_wd[1] = it_r.bytes_written - lbw_q;
    hn_wd[0] = it_r.read_ops - lro_q;
    hn_wd[1] = it_r.write_ops - lwo_q;
    hn_wd[2] = it_r.wait_count + it_r.run_count;
    case (state_r)
      S_CLEAR: begin
        h_we = 1'b1;
        h_waddr = clr_r;
        hw_wd[0] = '0; hw_wd[1] = '0;
        hn_wd[0] = '0; hn_wd[1] = '0; hn_wd[2] = '0;
      end
      S_SAMPLE: begin
        d_we = 1'b1;
        h_we = !first_r;
        h_waddr = {RowW'(idx_r + 1'b1), cur_r};
      end
      S_SUM: h_raddr = {RowW'(idx_r + 1'b1), cur_r};
      S_TOT: begin
        h_we = 1'b1;
        h_waddr = {RowW'(0), cur_r};
        hw_wd[0] = sw0_r; hw_wd[1] = sw1_r;
        hn_wd[0] = sn0_r; hn_wd[1] = sn1_r; hn_wd[2] = sn2_r;
      end
      // during accumulation the read address follows k_r, one entry ahead
      S_QRY, S_QACC: h_raddr = {row_r, k_r[SlotW-1:0]};
      default: ;
    endcase
  end

  assign q_pop = (state_r == S_IDLE) && !q_empty && !res_valid_r;
  assign res_valid = res_valid_r;
  assign res = res_r;
  assign clr_busy = (state_r == S_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      nused_r <= '0;
      cur_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == HistAw'(HistDepth - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (q_pop) begin
          it_r <= q_item;
          idx_r <= '0;
          res_r <= '0;
          sw0_r <= '0; sw1_r <= '0; sn0_r <= '0; sn1_r <= '0; sn2_r <= '0;
          case (q_item.func)
            FUNC_INTERVAL: state_r <= (nused_r == '0) ? S_TOT : S_SUM;
            FUNC_QTOT: begin
              row_r <= '0;
              k_r <= '0;
              state_r <= S_QRY;
            end
            default: state_r <= S_LOOK;
          endcase
        end
        // key ram read in flight
        S_LOOK: state_r <= S_LOOKCHK;
        S_LOOKCHK: begin
          if (idx_r == nused_r) begin
            if (it_r.func == FUNC_SAMPLE) begin
              if (nused_r == DevW'(Devices)) begin
                res_r.status <= ST_FULL;
                state_r <= S_OUT;
              end else begin
                first_r <= 1'b1;
                nused_r <= nused_r + 1'b1;
                state_r <= S_SAMPLE;
              end
            end else begin
              res_r.status <= ST_UNKNOWN;
              state_r <= S_OUT;
            end
          end else if (key_q == it_r.dev_key) begin
            if (it_r.func == FUNC_SAMPLE) begin
              first_r <= 1'b0;
              state_r <= S_SAMPLE;
            end else begin
              row_r <= RowW'(idx_r + 1'b1);
              k_r <= '0;
              state_r <= S_QRY;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_LOOK;
          end
        end
        S_SAMPLE: state_r <= S_OUT;
        S_SUM: state_r <= S_SUMACC;
        S_SUMACC: begin
          sw0_r <= sw0_r + hw_q[0];
          sw1_r <= sw1_r + hw_q[1];
          sn0_r <= sn0_r + hn_q[0];
          sn1_r <= sn1_r + hn_q[1];
          sn2_r <= sn2_r + hn_q[2];
          if (idx_r + 1'b1 == nused_r) state_r <= S_TOT;
          else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_SUM;
          end
        end
        S_TOT: begin
          cur_r <= cur_r + 1'b1;
          state_r <= S_OUT;
        end
        S_QRY: begin
          if (sel == SEL_BAD) begin
            res_r.status <= ST_UNSUP;
            state_r <= S_OUT;
          end else begin
            pend_r <= 1'b0;
            sum_r <= '0;
            state_r <= S_QACC;
            k_r <= k_r + 1'b1;
          end
        end
        // read data here is entry k-1; entry k is being read
        S_QACC: begin
          sum_r <= sum_r + elem;
          if (!pend_r || elem < mn_r) mn_r <= elem;
          if (!pend_r || elem > mx_r) mx_r <= elem;
          pend_r <= 1'b1;
          if (k_r == (SlotW + 1)'(History)) state_r <= S_DIV;
          else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DIV: begin
          if (kind == 2'd1) res_r.value <= mn_r;
          else if (kind == 2'd2) res_r.value <= mx_r;
          else if (series < 3'd3) begin
            res_r <= '{value: fx >> 8, value_frac: fx[7:0], status: ST_OK};
          end else res_r.value <= sum_r >> SlotW;
          state_r <= S_OUT;
        end
        S_OUT: if (!res_valid_r) begin
          res_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/icws_front.sv =====
// front end: accepts items and classifies query select codes
// depends on icws_pkg
`timescale 1ns / 1ps
module icws_front
  import icws_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t din,
  input  logic  block,
  output logic  full,
  output logic  q_push,
  output item_t q_item,
  input  logic  q_full
);
  item_t hold_r;
  item_t hold_nxt;
  logic valid_r;

  assign full = valid_r || block;
  assign q_push = valid_r;
  assign q_item = hold_r;

  always_comb begin
    hold_nxt = din;
    // out-of-range selects are folded to the single unsupported code
    if (din.stat_sel > 4'd14) hold_nxt.stat_sel = SEL_BAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (valid_r && !q_full) valid_r <= 1'b0;
      if (push && !full) begin
        hold_r <= hold_nxt;
        valid_r <= 1'b1;
      end
    end
  end
endmodule

// ===== src/io_counter_window_stats_unit.sv =====
// top level of the i/o counter window statistics unit
// depends on icws_pkg, icws_front, icws_queue, icws_back, icws_ram
`timescale 1ns / 1ps
// After reset the history memories are cleared (256 rows x 64 slots), while full
// stays high. A sample or device query walks the key table one slot at a time, a
// key read and then a compare per slot; an interval item sums the current slot over
// the n devices known; a query reads the 64 history entries one per cycle. One
// result per item, in order.
module io_counter_window_stats_unit
  import icws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_dev_key,
  input  logic [63:0] in_bytes_read,
  input  logic [63:0] in_bytes_written,
  input  logic [31:0] in_read_ops,
  input  logic [31:0] in_write_ops,
  input  logic [31:0] in_wait_count,
  input  logic [31:0] in_run_count,
  input  logic [3:0]  in_stat_sel,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_value,
  output logic [7:0]  out_value_frac,
  output logic [1:0]  out_status
);
  item_t din, fq_item, q_item;
  logic fq_push, fq_full, q_empty, q_pop, res_valid, clr_busy;
  result_t res;

  assign din = '{func: in_func, dev_key: in_dev_key, bytes_read: in_bytes_read,
    bytes_written: in_bytes_written, read_ops: in_read_ops,
    write_ops: in_write_ops, wait_count: in_wait_count,
    run_count: in_run_count, stat_sel: in_stat_sel};

  icws_front u_front (.clk, .rst_n, .push(in_push), .din, .block(clr_busy),
    .full(in_full), .q_push(fq_push), .q_item(fq_item), .q_full(fq_full));
  icws_queue u_queue (.clk, .rst_n, .push(fq_push), .din(fq_item), .full(fq_full),
    .pop(q_pop), .dout(q_item), .empty(q_empty));
  icws_back u_back (.clk, .rst_n, .q_empty, .q_item, .q_pop, .res_valid, .res,
    .res_ready(out_pop), .clr_busy);

  assign out_empty = !res_valid;
  assign out_value = res.value;
  assign out_value_frac = res.value_frac;
  assign out_status = res.status;

  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> in_full) else $error("accepting during clear");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |-> (out_value == 64'd0))
    else $error("error result carries a value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty) else $error("result lost");
endmodule

// ===== tb/sv/tb_io_counter_window_stats_unit.sv =====
// testbench for io_counter_window_stats_unit: directed table, then random samples,
// intervals and queries checked against an in-bench model; depends on icws_pkg
`timescale 1ns / 1ps
module tb_io_counter_window_stats_unit;
  import icws_pkg::*;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_func = '0;
  logic [63:0] in_dev_key = '0;
  logic [63:0] in_bytes_read = '0;
  logic [63:0] in_bytes_written = '0;
  logic [31:0] in_read_ops = '0;
  logic [31:0] in_write_ops = '0;
  logic [31:0] in_wait_count = '0;
  logic [31:0] in_run_count = '0;
  logic [3:0]  in_stat_sel = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [63:0] out_value;
  logic [7:0]  out_value_frac;
  logic [1:0]  out_status;

  io_counter_window_stats_unit dut (.*);

  always #5 clk = ~clk;

  // device table and history window kept by the bench
  logic [63:0] dev_key_tab [Devices];
  bit          dev_used [Devices];
  int          dev_count;
  logic [63:0] prev_br [Devices];
  logic [63:0] prev_bw [Devices];
  logic [31:0] prev_ro [Devices];
  logic [31:0] prev_wo [Devices];
  logic [63:0] win_rb [Rows][History];
  logic [63:0] win_wb [Rows][History];
  logic [31:0] win_rd [Rows][History];
  logic [31:0] win_wr [Rows][History];
  logic [31:0] win_q [Rows][History];
  int          cur_slot;

  result_t expected_q[$];
  stim_t   directed_q[$];
  int      errors;
  int      mismatches;
  bit      quiet;

  function automatic logic [63:0] win_entry(int row, int series, int k);
    case (series)
      0: return {32'd0, win_rd[row][k]};
      1: return {32'd0, win_wr[row][k]};
      2: return {32'd0, win_q[row][k]};
      3: return win_rb[row][k];
      default: return win_wb[row][k];
    endcase
  endfunction

  function automatic result_t window_stat(int row, logic [3:0] sel);
    result_t r;
    int series;
    int kind;
    logic [63:0] v;
    logic [63:0] sum;
    logic [63:0] mn;
    logic [63:0] mx;
    logic [63:0] fx;
    r = '{64'd0, 8'd0, ST_OK};
    if (sel == SEL_BAD) begin
      r.status = ST_UNSUP;
      return r;
    end
    series = sel / 3;
    kind = sel % 3;
    sum = 0;
    mn = win_entry(row, series, 0);
    mx = mn;
    for (int k = 0; k < History; k++) begin
      v = win_entry(row, series, k);
      sum += v;
      if (v < mn) mn = v;
      if (v > mx) mx = v;
    end
    if (kind == 0) begin
      if (series < 3) begin
        fx = (sum << 8) / History;
        r.value = fx >> 8;
        r.value_frac = fx[7:0];
      end else begin
        r.value = sum / History;
      end
    end else begin
      r.value = (kind == 1) ? mn : mx;
    end
    return r;
  endfunction

  function automatic int lookup_dev(logic [63:0] key);
    for (int i = 0; i < Devices; i++) begin
      if (!dev_used[i]) return -1;
      if (dev_key_tab[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic result_t window_update(item_t it);
    result_t r;
    int slot;
    logic [63:0] s0;
    logic [63:0] s1;
    logic [31:0] s2;
    logic [31:0] s3;
    logic [31:0] s4;
    r = '{64'd0, 8'd0, ST_OK};
    case (it.func)
      FUNC_SAMPLE: begin
        slot = -1;
        for (int i = 0; i < Devices; i++) begin
          if (!dev_used[i] || dev_key_tab[i] == it.dev_key) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          if (!dev_used[slot]) begin
            dev_used[slot] = 1'b1;
            dev_key_tab[slot] = it.dev_key;
            dev_count++;
          end else begin
            win_rb[slot + 1][cur_slot] = it.bytes_read - prev_br[slot];
            win_wb[slot + 1][cur_slot] = it.bytes_written - prev_bw[slot];
            win_rd[slot + 1][cur_slot] = it.read_ops - prev_ro[slot];
            win_wr[slot + 1][cur_slot] = it.write_ops - prev_wo[slot];
            win_q[slot + 1][cur_slot] = it.wait_count + it.run_count;
          end
          prev_br[slot] = it.bytes_read;
          prev_bw[slot] = it.bytes_written;
          prev_ro[slot] = it.read_ops;
          prev_wo[slot] = it.write_ops;
        end
      end
      FUNC_INTERVAL: begin
        s0 = 0; s1 = 0; s2 = 0; s3 = 0; s4 = 0;
        for (int i = 0; i < Devices && dev_used[i]; i++) begin
          s0 += win_rb[i + 1][cur_slot];
          s1 += win_wb[i + 1][cur_slot];
          s2 += win_rd[i + 1][cur_slot];
          s3 += win_wr[i + 1][cur_slot];
          s4 += win_q[i + 1][cur_slot];
        end
        win_rb[0][cur_slot] = s0;
        win_wb[0][cur_slot] = s1;
        win_rd[0][cur_slot] = s2;
        win_wr[0][cur_slot] = s3;
        win_q[0][cur_slot] = s4;
        cur_slot = (cur_slot + 1) % History;
      end
      FUNC_QDEV: begin
        slot = lookup_dev(it.dev_key);
        if (slot < 0) r.status = ST_UNKNOWN;
        else r = window_stat(slot + 1, it.stat_sel);
      end
      default: r = window_stat(0, it.stat_sel);
    endcase
    return r;
  endfunction

  function automatic item_t mk(logic [1:0] f, logic [63:0] key, logic [63:0] br,
                               logic [63:0] bw, logic [31:0] ro, logic [31:0] wo,
                               logic [31:0] wc, logic [31:0] rc, logic [3:0] sel);
    item_t it;
    it.func = f; it.dev_key = key; it.bytes_read = br; it.bytes_written = bw;
    it.read_ops = ro; it.write_ops = wo; it.wait_count = wc; it.run_count = rc;
    it.stat_sel = sel;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send(item_t it, bit typed, result_t want);
    result_t r;
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_func <= it.func;
    in_dev_key <= it.dev_key;
    in_bytes_read <= it.bytes_read;
    in_bytes_written <= it.bytes_written;
    in_read_ops <= it.read_ops;
    in_write_ops <= it.write_ops;
    in_wait_count <= it.wait_count;
    in_run_count <= it.run_count;
    in_stat_sel <= it.stat_sel;
    do @(negedge clk); while (in_full);
    r = window_update(it);
    expected_q.push_back(typed ? want : r);
    @(posedge clk);
  endtask

  always @(posedge clk) out_pop <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 12);

  // inputs change only at rising edges, so the negedge view is what the next edge takes
  always @(negedge clk) begin
    result_t w;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected transaction: value %h frac %h status %0d",
                   out_value, out_value_frac, out_status);
      end else begin
        w = expected_q.pop_front();
        if (out_value !== w.value || out_value_frac !== w.value_frac ||
            out_status !== w.status) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected %h/%h/%0d got %h/%h/%0d", w.value,
                     w.value_frac, w.status, out_value, out_value_frac, out_status);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [63:0] pool [8];
    logic [63:0] cbr [8];
    logic [63:0] cbw [8];
    logic [31:0] cro [8];
    logic [31:0] cwo [8];
    localparam logic [63:0] KA = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KB = 64'h0;
    localparam logic [63:0] M64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] M32 = 32'hFFFF_FFFF;
    result_t okz;
    item_t it;
    int p;
    int pick;
    logic [63:0] key;

    for (int i = 0; i < Devices; i++) dev_used[i] = 1'b0;
    for (int r = 0; r < Rows; r++)
      for (int k = 0; k < History; k++) begin
        win_rb[r][k] = 0; win_wb[r][k] = 0; win_rd[r][k] = 0;
        win_wr[r][k] = 0; win_q[r][k] = 0;
      end
    okz = '{64'd0, 8'd0, ST_OK};

    directed_q.push_back('{mk(FUNC_QTOT, 0, 0, 0, 0, 0, 0, 0, 4'd0), 1, okz});
    directed_q.push_back('{mk(FUNC_QTOT, 0, 0, 0, 0, 0, 0, 0, 4'd14), 1, okz});
    directed_q.push_back('{mk(FUNC_QDEV, KA, 0, 0, 0, 0, 0, 0, 4'd0), 1,
                           '{64'd0, 8'd0, ST_UNKNOWN}});
    // unknown device wins over a bad selector
    directed_q.push_back('{mk(FUNC_QDEV, KA, 0, 0, 0, 0, 0, 0, SEL_BAD), 1,
                           '{64'd0, 8'd0, ST_UNKNOWN}});
    directed_q.push_back('{mk(FUNC_QTOT, KA, 0, 0, 0, 0, 0, 0, SEL_BAD), 1,
                           '{64'd0, 8'd0, ST_UNSUP}});
    directed_q.push_back('{mk(FUNC_SAMPLE, KA, M64, M64, M32, M32, M32, M32, 4'd15), 1, okz});
    directed_q.push_back('{mk(FUNC_SAMPLE, KB, 0, 0, 0, 0, 0, 0, 4'd0), 1, okz});
    // counters wrap from all ones to zero
    directed_q.push_back('{mk(FUNC_SAMPLE, KA, 0, 0, 0, 0, 5, 7, 4'd0), 0, okz});
    directed_q.push_back('{mk(FUNC_SAMPLE, KB, M64, M64, M32, M32, M32, 32'd2, 4'd0), 0, okz});
    directed_q.push_back('{mk(FUNC_INTERVAL, 0, 0, 0, 0, 0, 0, 0, 4'd0), 1, okz});
    for (int s = 0; s < 15; s++)
      directed_q.push_back('{mk(FUNC_QDEV, KB, 0, 0, 0, 0, 0, 0, s[3:0]), 0, okz});
    directed_q.push_back('{mk(FUNC_QTOT, 0, 0, 0, 0, 0, 0, 0, 4'd0), 0, okz});
    directed_q.push_back('{mk(FUNC_QTOT, 0, 0, 0, 0, 0, 0, 0, 4'd11), 0, okz});
    directed_q.push_back('{mk(FUNC_QTOT, 0, 0, 0, 0, 0, 0, 0, 4'd8), 0, okz});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) send(directed_q[i].it, directed_q[i].typed, directed_q[i].want);

    for (int i = 0; i < 8; i++) begin
      pool[i] = rand64();
      cbr[i] = rand64(); cbw[i] = rand64(); cro[i] = $urandom(); cwo[i] = $urandom();
    end
    for (int n = 0; n < 350; n++) begin
      quiet = (n >= 150 && n < 250);
      if (n == 200) begin
        in_push <= 1'b0;
        wait (expected_q.size() == 0);
        @(posedge clk);
      end
      p = $urandom_range(0, 99);
      pick = $urandom_range(0, 7);
      key = ($urandom_range(0, 19) == 0) ? rand64() : pool[pick];
      if (p < 50) begin
        // mostly steady counter growth, sometimes a jump anywhere
        if ($urandom_range(0, 9) < 8) begin
          cbr[pick] += $urandom_range(0, 100000);
          cbw[pick] += $urandom_range(0, 100000);
          cro[pick] += $urandom_range(0, 500);
          cwo[pick] += $urandom_range(0, 500);
        end else begin
          cbr[pick] = rand64(); cbw[pick] = rand64();
          cro[pick] = $urandom(); cwo[pick] = $urandom();
        end
        it = mk(FUNC_SAMPLE, key, cbr[pick], cbw[pick], cro[pick], cwo[pick],
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20),
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20),
                4'($urandom_range(0, 15)));
      end else if (p < 65) begin
        it = mk(FUNC_INTERVAL, rand64(), rand64(), rand64(), $urandom(), $urandom(),
                $urandom(), $urandom(), 4'($urandom_range(0, 15)));
      end else begin
        it = mk(p < 90 ? FUNC_QDEV : FUNC_QTOT, key, rand64(), rand64(), $urandom(),
                $urandom(), $urandom(), $urandom(), 4'($urandom_range(0, 15)));
      end
      send(it, 0, okz);
    end
    quiet = 0;

    // fill the key table, then push new keys into a full table, mixed with known-key samples, intervals and queries
    while (dev_count < Devices)
      send(mk(FUNC_SAMPLE, rand64(), rand64(), rand64(), $urandom(), $urandom(),
              $urandom(), $urandom(), 4'd0), 0, okz);
    for (int n = 0; n < 20; n++) begin
      case (n % 4)
        0: it = mk(FUNC_SAMPLE, rand64(), rand64(), rand64(), $urandom(), $urandom(),
                   $urandom(), $urandom(), 4'd0);
        1: it = mk(FUNC_SAMPLE, dev_key_tab[$urandom_range(0, Devices - 1)], rand64(),
                   rand64(), $urandom(), $urandom(), $urandom(), $urandom(), 4'd0);
        2: it = mk(FUNC_INTERVAL, 0, 0, 0, 0, 0, 0, 0, 4'd0);
        default: it = mk($urandom_range(0, 1) ? FUNC_QTOT : FUNC_QDEV,
                         dev_key_tab[Devices - 1], 0, 0, 0, 0, 0, 0,
                         4'($urandom_range(0, 15)));
      endcase
      send(it, 0, okz);
    end
    in_push <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/icws_pkg.sv
src/icws_ram.sv
src/icws_queue.sv
src/icws_back.sv
src/icws_front.sv
src/io_counter_window_stats_unit.sv
tb/sv/tb_io_counter_window_stats_unit.sv
